>>> src/fwbu_pkg.sv
// ----------------------------------------------------------------------------
// fwbu_pkg: shared types and constants of the fixed-width bit unpacker
// Word layouts, lane count and field widths used by every stage.
// ----------------------------------------------------------------------------
package fwbu_pkg;

	localparam int MAX_LANES   = 8;
	localparam int LANES_DEF   = 8;
	localparam int WIN_BITS    = 256;
	localparam int VAL_BITS    = 25;
	localparam int WIDTH_BITS  = 5;
	localparam int OFF_BITS    = 3;
	localparam int POS_BITS    = 8;
	localparam int CHUNK_BITS  = 32;
	localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(17);
	localparam logic [WIDTH_BITS-1:0] WIDTH_CLIP  = WIDTH_BITS'(VAL_BITS);

	typedef struct packed {
		logic [63:0]         window_word0;
		logic [63:0]         window_word1;
		logic [63:0]         window_word2;
		logic [63:0]         window_word3;
		logic [OFF_BITS-1:0] bit_offset;
	} src_word_t;

	typedef struct packed {
		logic [VAL_BITS-1:0] value0;
		logic [VAL_BITS-1:0] value1;
		logic [VAL_BITS-1:0] value2;
		logic [VAL_BITS-1:0] value3;
		logic [VAL_BITS-1:0] value4;
		logic [VAL_BITS-1:0] value5;
		logic [VAL_BITS-1:0] value6;
		logic [VAL_BITS-1:0] value7;
	} dst_word_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} adv_t;

	typedef logic [MAX_LANES-1:0][POS_BITS-1:0] pos_vec_t;
	typedef logic [MAX_LANES-1:0][VAL_BITS-1:0] val_vec_t;

endpackage

>>> src/fwbu_position.sv
// ----------------------------------------------------------------------------
// fwbu_position: stage one of the unpacker
// Registers the window and the start bit of every lane, offset plus lane
// times width, and the width clipped to the result field.
// ----------------------------------------------------------------------------
module fwbu_position
	import fwbu_pkg::*;
#(
	parameter int LANES = LANES_DEF
) (
	input  logic                  clk,
	input  adv_t                  adv,
	input  src_word_t             src_word,
	input  logic [WIDTH_BITS-1:0] entry_width,
	output logic [WIN_BITS-1:0]   window_s1,
	output pos_vec_t              pos_s1,
	output logic [WIDTH_BITS-1:0] wclip_s1
);

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			window_s1 <= {src_word.window_word3, src_word.window_word2,
				src_word.window_word1, src_word.window_word0};
			wclip_s1  <= (entry_width > WIDTH_CLIP) ? WIDTH_CLIP : entry_width;
			for (int k = 0; k < MAX_LANES; k++) begin
				if (k < LANES) begin
					pos_s1[k] <= POS_BITS'(src_word.bit_offset)
						+ POS_BITS'(k) * POS_BITS'(entry_width);
				end else begin
					pos_s1[k] <= '0;
				end
			end
		end
	end

endmodule

>>> src/fwbu_extract.sv
// ----------------------------------------------------------------------------
// fwbu_extract: stages two and three of the unpacker
// Stage two picks the 32-bit chunk at the start byte of each lane; stage
// three aligns it by the remaining bit shift and masks to the entry width.
// ----------------------------------------------------------------------------
module fwbu_extract
	import fwbu_pkg::*;
#(
	parameter int LANES = LANES_DEF
) (
	input  logic                  clk,
	input  adv_t                  adv,
	input  logic [WIN_BITS-1:0]   window_s1,
	input  pos_vec_t              pos_s1,
	input  logic [WIDTH_BITS-1:0] wclip_s1,
	output val_vec_t              value_s3
);

	logic [WIDTH_BITS-1:0] wclip_s2;
	logic [VAL_BITS:0]     mask_full;

	assign mask_full  = (VAL_BITS+1)'(((VAL_BITS+1)'(1) << wclip_s2) - (VAL_BITS+1)'(1));

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			wclip_s2 <= wclip_s1;
		end
	end

	for (genvar k = 0; k < MAX_LANES; k++) begin : g_lane
		if (k < LANES) begin : g_on
			logic [CHUNK_BITS-1:0] chunk_s2;
			logic [OFF_BITS-1:0]   shift_s2;
			logic [CHUNK_BITS-1:0] aligned;
			logic [VAL_BITS-1:0]   value_q3;

			assign aligned = chunk_s2 >> shift_s2;

			// the last lane starts at byte 28 at most, so the chunk stays in the window
			always_ff @(posedge clk) begin
				if (adv.s2) begin
					chunk_s2 <= window_s1[{pos_s1[k][POS_BITS-1:OFF_BITS], 3'b000} +: CHUNK_BITS];
					shift_s2 <= pos_s1[k][OFF_BITS-1:0];
				end
				if (adv.s3) begin
					value_q3 <= aligned[VAL_BITS-1:0] & mask_full[VAL_BITS-1:0];
				end
			end

			assign value_s3[k] = value_q3;
		end else begin : g_off
			assign value_s3[k] = '0;
		end
	end

endmodule

>>> src/fixed_width_bit_unpacker.sv
// ----------------------------------------------------------------------------
// fixed_width_bit_unpacker: eight-lane fixed-width bit unpacker
// Splits a 256-bit packed window into consecutive entries of a programmed
// width, each zero-extended into its own result field.
// ----------------------------------------------------------------------------
//  channel  | signals                        | moves
//  src      | src_valid, src_stall, src_word | window plus start bit offset
//  dst      | dst_valid, dst_stall, dst_word | eight unpacked values
//  config   | wr_en, wr_data                 | entry width, reset value 17
//
//  Three register stages: lane start positions, byte select, bit align and
//  mask. One word enters and one leaves per cycle while dst is not stalled.
//  Reset clears the stage valid bits and loads the entry width.
//  A stall on dst holds the full stages; bubbles ahead of it still fill.
// ----------------------------------------------------------------------------
module fixed_width_bit_unpacker
	import fwbu_pkg::*;
#(
	parameter int LANES = LANES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  src_valid,
	output logic                  src_stall,
	input  src_word_t             src_word,
	output logic                  dst_valid,
	input  logic                  dst_stall,
	output dst_word_t             dst_word,
	input  logic                  wr_en,
	input  logic [WIDTH_BITS-1:0] wr_data
);

	logic [WIDTH_BITS-1:0] entry_width_q;
	logic                  valid_s1;
	logic                  valid_s2;
	logic                  valid_s3;
	adv_t                  adv;
	logic [WIN_BITS-1:0]   window_s1;
	pos_vec_t              pos_s1;
	logic [WIDTH_BITS-1:0] wclip_s1;
	val_vec_t              value_s3;

	// advance a stage when it is empty or the next one moves
	assign adv.s3    = !valid_s3 || !dst_stall;
	assign adv.s2    = !valid_s2 || adv.s3;
	assign adv.s1    = !valid_s1 || adv.s2;
	assign src_stall = !adv.s1;
	assign dst_valid = valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_width_q <= WIDTH_RESET;
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			valid_s3      <= 1'b0;
		end else begin
			if (wr_en) begin
				entry_width_q <= wr_data;
			end
			if (adv.s1) begin
				valid_s1 <= src_valid;
			end
			if (adv.s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv.s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	fwbu_position #(
		.LANES(LANES)
	) u_position (
		.clk        (clk),
		.adv        (adv),
		.src_word   (src_word),
		.entry_width(entry_width_q),
		.window_s1  (window_s1),
		.pos_s1     (pos_s1),
		.wclip_s1   (wclip_s1)
	);

	fwbu_extract #(
		.LANES(LANES)
	) u_extract (
		.clk      (clk),
		.adv      (adv),
		.window_s1(window_s1),
		.pos_s1   (pos_s1),
		.wclip_s1 (wclip_s1),
		.value_s3 (value_s3)
	);

	assign dst_word.value0 = value_s3[0];
	assign dst_word.value1 = value_s3[1];
	assign dst_word.value2 = value_s3[2];
	assign dst_word.value3 = value_s3[3];
	assign dst_word.value4 = value_s3[4];
	assign dst_word.value5 = value_s3[5];
	assign dst_word.value6 = value_s3[6];
	assign dst_word.value7 = value_s3[7];

endmodule
